[rtl/core/cht_pkg.sv]
// Shared types and codes for the chained hash table.
// No dependencies.
package cht_pkg;

    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam int DIGITS = 5;   // base-100 digits of a 31-bit key

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_DIGIT,
        FE_MOD,
        FE_PUSH
    } fe_state_t;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_HEAD,
        BE_READ,
        BE_CMP,
        BE_OUT
    } be_state_t;

endpackage

[rtl/core/cht_front.sv]
// Front end: accept requests and compute the bucket index digit by digit.
// Depends on cht_pkg.
module cht_front #(
    parameter int BUCKETS = 100,
    parameter int BW      = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          in_op,
    input  logic [30:0]   in_key,
    input  logic [31:0]   in_value,
    output logic          q_valid,
    input  logic          q_ready,
    output logic [64+BW-1:0] q_data   // {bucket, value, key, op}
);
    import cht_pkg::*;

    localparam int SW = 11;   // digit sum <= 5*99

    fe_state_t  state_reg, state_next;
    logic       op_reg;
    logic [30:0] key_reg, rem_reg;
    logic [31:0] value_reg;
    logic [SW-1:0] sum_reg;
    logic [2:0]  cnt_reg;

    logic [30:0] quo;
    logic [6:0]  dig;
    logic [62:0] prod;

    // divide by 100 through the reciprocal ceil(2^37/100); the rounding error
    // stays below one unit for any 31-bit key, so the quotient is exact
    assign prod = {32'd0, rem_reg} * 63'd1374389535;
    assign quo  = 31'(prod[62:37]);
    assign dig  = 7'(rem_reg - 31'(quo * 31'd100));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FE_IDLE:  if (in_valid) state_next = FE_DIGIT;
            FE_DIGIT: if (cnt_reg == 3'(DIGITS - 1)) state_next = FE_MOD;
            FE_MOD:   if (sum_reg < SW'(BUCKETS)) state_next = FE_PUSH;
            FE_PUSH:  if (q_ready) state_next = FE_IDLE;
            default:  state_next = FE_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == FE_IDLE);
        q_valid  = (state_reg == FE_PUSH);
        q_data   = {BW'(sum_reg), value_reg, key_reg, op_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FE_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            FE_IDLE:
            begin
                op_reg <= in_op; key_reg <= in_key; rem_reg <= in_key;
                value_reg <= in_value; sum_reg <= '0; cnt_reg <= '0;
            end
            FE_DIGIT:
            begin
                sum_reg <= sum_reg + SW'(dig);
                rem_reg <= quo;
                cnt_reg <= cnt_reg + 3'd1;
            end
            FE_MOD:
                if (sum_reg >= SW'(BUCKETS)) sum_reg <= sum_reg - SW'(BUCKETS);
            default: ;
        endcase
    end
endmodule

[rtl/core/cht_queue.sv]
// Two-entry queue between front and back ends.
// No dependencies.
module cht_queue #(
    parameter int W = 71
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [W-1:0] s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [W-1:0] m_data
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         wr, rd;

    assign s_ready = (cnt_reg != 2'd2);
    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = mem_reg[rp_reg];
    assign wr = s_valid && s_ready;
    assign rd = m_valid && m_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= s_data;
    end
endmodule

[rtl/core/cht_back.sv]
// Back end: bucket heads, node pool and the chain walk.
// Depends on cht_pkg.
module cht_back #(
    parameter int BUCKETS = 100,
    parameter int NODES   = 256,
    parameter int BW      = 7,
    parameter int NW      = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  logic [64+BW-1:0] q_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [41:0]   out_data   // {busy, bucket, value_out, status}
);
    import cht_pkg::*;

    be_state_t state_reg, state_next;

    logic [NW-1:0] head_mem [BUCKETS];
    logic [BUCKETS-1:0] head_vld_reg;
    logic [30:0]   key_mem  [NODES];
    logic [31:0]   val_mem  [NODES];
    logic [NW:0]   link_mem [NODES];   // {valid, index}

    logic [NW:0]   used_reg;
    logic          op_reg, busy_reg;
    logic [30:0]   key_reg;
    logic [31:0]   value_reg, found_reg;
    logic [BW-1:0] bkt_reg;
    logic [1:0]    status_reg;
    logic [NW-1:0] head_rd_reg, ptr_reg;
    logic [30:0]   nkey_reg;
    logic [31:0]   nval_reg;
    logic [NW:0]   nlink_reg;
    logic          full;

    assign full = (used_reg == (NW+1)'(NODES));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BE_IDLE: if (q_valid) state_next = BE_HEAD;
            BE_HEAD:
                if (op_reg == OP_PUT || !busy_reg) state_next = BE_OUT;
                else state_next = BE_READ;
            BE_READ: state_next = BE_CMP;
            BE_CMP:
                if (nkey_reg == key_reg || !nlink_reg[NW]) state_next = BE_OUT;
                else state_next = BE_READ;
            BE_OUT: if (out_ready) state_next = BE_IDLE;
            default: state_next = BE_IDLE;
        endcase
    end

    always_comb
    begin
        q_ready   = (state_reg == BE_IDLE);
        out_valid = (state_reg == BE_OUT);
        out_data  = {busy_reg, 7'(bkt_reg), found_reg, status_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BE_IDLE;
            head_vld_reg <= '0;
            used_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BE_HEAD && op_reg == OP_PUT && !full)
            begin
                head_vld_reg[bkt_reg] <= 1'b1;
                used_reg <= used_reg + (NW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BE_IDLE:
            begin
                op_reg    <= q_data[0];
                key_reg   <= q_data[31:1];
                value_reg <= q_data[63:32];
                bkt_reg   <= q_data[64 +: BW];
                busy_reg  <= head_vld_reg[q_data[64 +: BW]];
                head_rd_reg <= head_mem[q_data[64 +: BW]];
                found_reg <= '0;
            end
            BE_HEAD:
            begin
                ptr_reg <= head_rd_reg;
                if (op_reg == OP_PUT)
                begin
                    if (full)
                        status_reg <= ST_FULL;
                    else
                    begin
                        status_reg <= ST_OK;
                        key_mem[used_reg[NW-1:0]]  <= key_reg;
                        val_mem[used_reg[NW-1:0]]  <= value_reg;
                        link_mem[used_reg[NW-1:0]] <= {busy_reg, head_rd_reg};
                        head_mem[bkt_reg] <= used_reg[NW-1:0];
                    end
                end
                else
                    status_reg <= ST_NOTFOUND;
            end
            BE_READ:
            begin
                nkey_reg  <= key_mem[ptr_reg];
                nval_reg  <= val_mem[ptr_reg];
                nlink_reg <= link_mem[ptr_reg];
            end
            BE_CMP:
            begin
                if (nkey_reg == key_reg)
                begin
                    status_reg <= ST_OK;
                    found_reg  <= nval_reg;
                end
                ptr_reg <= nlink_reg[NW-1:0];
            end
            default: ;
        endcase
    end
endmodule

[rtl/core/chained_hash_table.sv]
// Chained hash table, top level.
// Depends on cht_pkg, cht_front, cht_queue, cht_back.
//
// Usage:
//   Requests enter on the s_axis group; one result per request leaves on
//   m_axis in request order. Request tuser = op, tdata = {value, key};
//   result tuser = status, tdata = {chain_was_busy, bucket, value_out}.
//   The front end takes apart the key into base-100 digits, one digit a
//   cycle, then folds the sum into the bucket range.
//   A two-entry queue lets the front end hash the next request while the
//   back end works. The back end keeps bucket heads in a memory with a
//   valid bit per bucket and the node pool in memories.
// Steps per request:
//   The front end sums the digits and subtracts the bucket count while
//   the sum is not below it. A put then writes a node at the chain head;
//   a get on a busy bucket reads and compares chain nodes in turn over
//   the node memory read port until the key matches or the chain ends.
// Reset clears the valid bits of all chain heads and the pool count.
// A stalled m_axis receiver holds the result; the queue then fills and
// s_axis_tready drops.
module chained_hash_table #(
    parameter int BUCKETS = 100,
    parameter int NODES   = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic        s_axis_tuser,   // op[0]
    input  logic [63:0] s_axis_tdata,   // key[30:0], value[62:31]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic [39:0] m_axis_tdata    // value_out[31:0], bucket[38:32],
                                        // chain_was_busy[39]
);
    import cht_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;

    logic          fq_valid, fq_ready, qb_valid, qb_ready;
    logic [64+BW-1:0] fq_data, qb_data;
    logic [41:0]   res;

    cht_front #(.BUCKETS(BUCKETS), .BW(BW)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_op(s_axis_tuser), .in_key(s_axis_tdata[30:0]),
        .in_value(s_axis_tdata[62:31]),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    cht_queue #(.W(64+BW)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .s_valid(fq_valid), .s_ready(fq_ready), .s_data(fq_data),
        .m_valid(qb_valid), .m_ready(qb_ready), .m_data(qb_data)
    );

    cht_back #(.BUCKETS(BUCKETS), .NODES(NODES), .BW(BW), .NW(NW)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
    );

    assign m_axis_tuser = res[1:0];
    assign m_axis_tdata = res[41:2];
endmodule
